>>> rtl/core/pwi_pkg.sv
// Shared types, codes and fixed widths of the windowed-integral position controller.
package pwi_pkg;

    localparam int POS_W      = 24;
    localparam int TARGET_W   = 24;
    localparam int SPEED_W    = 16;
    localparam int DRIVE_W    = 16;
    localparam int GAIN_W     = 24;
    localparam int STEP_W     = 12;
    localparam int TOL_W      = 8;
    localparam int FRAC_BITS  = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_BUTTON = 2'd1,
        CMD_LOAD   = 2'd2
    } cmd_t;

    localparam int BTN_DIR_BIT  = 0;
    localparam int BTN_SIZE_BIT = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LARGE_STEP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_TOL    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_TOL  = 3'd6;

    localparam logic signed [GAIN_W-1:0] GAIN_P_RST = 24'sd196608;
    localparam logic signed [GAIN_W-1:0] GAIN_I_RST = 24'sd66;
    localparam logic signed [GAIN_W-1:0] GAIN_D_RST = -24'sd655;
    localparam logic [STEP_W-1:0]        SMALL_STEP_RST = 12'd10;
    localparam logic [STEP_W-1:0]        LARGE_STEP_RST = 12'd90;
    localparam logic [TOL_W-1:0]         POS_TOL_RST    = 8'd1;
    localparam logic [TOL_W-1:0]         SPEED_TOL_RST  = 8'd2;

    typedef struct packed {
        logic                valid;
        logic                tick;
        logic                stop;
        logic                reached;
        logic [TARGET_W-1:0] target;
    } stage_t;

endpackage

>>> rtl/core/pwi_ring.sv
// Error ring memory with running window sum; a slot is read into stage s1 and written back from s1.
module pwi_ring #(
    parameter int WINDOW_DEPTH = 10,
    parameter int ERR_W        = 25,
    parameter int SUM_W        = 29
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              en,
    input  pwi_pkg::stage_t                   in_ctrl,
    input  logic signed [ERR_W-1:0]           in_error,
    input  logic signed [pwi_pkg::SPEED_W-1:0] in_speed,
    output pwi_pkg::stage_t                   out_ctrl,
    output logic signed [ERR_W-1:0]           out_error,
    output logic signed [pwi_pkg::SPEED_W-1:0] out_speed,
    output logic signed [SUM_W-1:0]           out_sum
);
    import pwi_pkg::*;

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

    logic [ERR_W-1:0]              mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0]       written_reg;
    logic [IDX_W-1:0]              idx_reg;
    logic [IDX_W-1:0]              idx_next;
    logic signed [SUM_W-1:0]       sum_reg;
    logic signed [SUM_W-1:0]       sum_next;

    stage_t                        s1_ctrl_reg;
    logic signed [ERR_W-1:0]       s1_error_reg;
    logic signed [SPEED_W-1:0]     s1_speed_reg;
    logic [IDX_W-1:0]              s1_idx_reg;
    logic [ERR_W-1:0]              rd_data_reg;
    logic                          rd_valid_reg;

    stage_t                        s2_ctrl_reg;
    logic signed [ERR_W-1:0]       s2_error_reg;
    logic signed [SPEED_W-1:0]     s2_speed_reg;
    logic signed [SUM_W-1:0]       s2_sum_reg;

    logic                          rd_tick;
    logic                          wr_tick;
    logic signed [ERR_W-1:0]       old_error;

    assign rd_tick   = en && in_ctrl.valid && in_ctrl.tick;
    assign wr_tick   = en && s1_ctrl_reg.valid && s1_ctrl_reg.tick;
    assign old_error = rd_valid_reg ? signed'(rd_data_reg) : '0;
    assign sum_next  = sum_reg - SUM_W'(old_error) + SUM_W'(s1_error_reg);
    assign idx_next  = (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (wr_tick) begin
            mem[s1_idx_reg] <= s1_error_reg;
        end
        if (en) begin
            rd_data_reg <= mem[idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            written_reg       <= '0;
            idx_reg           <= '0;
            sum_reg           <= '0;
            s1_ctrl_reg.valid <= 1'b0;
            s2_ctrl_reg.valid <= 1'b0;
            rd_valid_reg      <= 1'b0;
        end else begin
            if (rd_tick) begin
                idx_reg <= idx_next;
            end
            if (wr_tick) begin
                written_reg[s1_idx_reg] <= 1'b1;
                sum_reg                 <= sum_next;
            end
            if (en) begin
                s1_ctrl_reg  <= in_ctrl;
                s2_ctrl_reg  <= s1_ctrl_reg;
                rd_valid_reg <= written_reg[idx_reg];
                s1_error_reg <= in_error;
                s1_speed_reg <= in_speed;
                s1_idx_reg   <= idx_reg;
                s2_error_reg <= s1_error_reg;
                s2_speed_reg <= s1_speed_reg;
                s2_sum_reg   <= sum_next;
            end
        end
    end

    assign out_ctrl  = s2_ctrl_reg;
    assign out_error = s2_error_reg;
    assign out_speed = s2_speed_reg;
    assign out_sum   = s2_sum_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg <= IDX_LAST)
        else $error("ring index past last slot");

    a_no_same_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_tick && wr_tick |-> idx_reg != s1_idx_reg)
        else $error("ring read and write hit the same slot");

    a_sum_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !wr_tick |=> $stable(sum_reg))
        else $error("window sum changed without a tick write");

    a_slot_marked: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_tick |=> written_reg[$past(s1_idx_reg)])
        else $error("written slot not marked");

endmodule

>>> rtl/core/pwi_drive.sv
// Gain multiplies, sum, truncation toward zero and saturation of the drive word.
module pwi_drive #(
    parameter int ERR_W = 25,
    parameter int SUM_W = 29
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  pwi_pkg::stage_t                    in_ctrl,
    input  logic signed [ERR_W-1:0]            in_error,
    input  logic signed [pwi_pkg::SPEED_W-1:0] in_speed,
    input  logic signed [SUM_W-1:0]            in_sum,
    input  logic signed [pwi_pkg::GAIN_W-1:0]  gain_p,
    input  logic signed [pwi_pkg::GAIN_W-1:0]  gain_i,
    input  logic signed [pwi_pkg::GAIN_W-1:0]  gain_d,
    output pwi_pkg::stage_t                    out_ctrl,
    output logic signed [pwi_pkg::DRIVE_W-1:0] out_drive
);
    import pwi_pkg::*;

    localparam int P_W   = GAIN_W + ERR_W;
    localparam int I_W   = GAIN_W + SUM_W;
    localparam int D_W   = GAIN_W + SPEED_W;
    localparam int ACC_W = GAIN_W + SUM_W + 2;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 <<< (DRIVE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(1 <<< (DRIVE_W - 1));

    stage_t                    s3_ctrl_reg;
    logic signed [P_W-1:0]     p_prod_reg;
    logic signed [I_W-1:0]     i_prod_reg;
    logic signed [D_W-1:0]     d_prod_reg;

    stage_t                    s4_ctrl_reg;
    logic signed [ACC_W-1:0]   acc_reg;

    stage_t                    out_ctrl_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic signed [DRIVE_W-1:0] drive_next;

    logic signed [ACC_W-1:0]   quot;
    logic                      round_up;
    logic signed [ACC_W-1:0]   quot_tz;

    always_comb begin
        quot     = acc_reg >>> FRAC_BITS;
        round_up = acc_reg[ACC_W-1] && (|acc_reg[FRAC_BITS-1:0]);
        quot_tz  = quot + ACC_W'(round_up);
        if (!s4_ctrl_reg.tick || s4_ctrl_reg.stop) begin
            drive_next = '0;
        end else if (quot_tz > SAT_HI) begin
            drive_next = SAT_HI[DRIVE_W-1:0];
        end else if (quot_tz < SAT_LO) begin
            drive_next = SAT_LO[DRIVE_W-1:0];
        end else begin
            drive_next = quot_tz[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_ctrl_reg.valid  <= 1'b0;
            s4_ctrl_reg.valid  <= 1'b0;
            out_ctrl_reg.valid <= 1'b0;
        end else if (en) begin
            s3_ctrl_reg  <= in_ctrl;
            p_prod_reg   <= gain_p * in_error;
            i_prod_reg   <= gain_i * in_sum;
            d_prod_reg   <= gain_d * in_speed;
            s4_ctrl_reg  <= s3_ctrl_reg;
            acc_reg      <= ACC_W'(p_prod_reg) + ACC_W'(i_prod_reg)
                            + ACC_W'(d_prod_reg);
            out_ctrl_reg <= s4_ctrl_reg;
            drive_reg    <= drive_next;
        end
    end

    assign out_ctrl  = out_ctrl_reg;
    assign out_drive = drive_reg;

    a_sign_follows_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        en && s4_ctrl_reg.valid && s4_ctrl_reg.tick && !s4_ctrl_reg.stop
        |=> drive_reg == '0 || drive_reg[DRIVE_W-1] == $past(acc_reg[ACC_W-1]))
        else $error("drive sign differs from accumulator sign");

    a_idle_drive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        en && s4_ctrl_reg.valid && (!s4_ctrl_reg.tick || s4_ctrl_reg.stop)
        |=> drive_reg == '0)
        else $error("nonzero drive for a stop or non-tick word");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(out_ctrl_reg) && $stable(drive_reg))
        else $error("output stage changed while stalled");

endmodule

>>> rtl/core/pid_position_windowed_integral.sv
// Top level of the motor position controller with sliding-window integral.
//
//  channel  | handshake              | payload
//  ---------+------------------------+---------------------------------------------
//  s_       | s_valid / s_ready      | s_cmd, s_position, s_angular_speed, s_button
//  m_       | m_valid / m_ready      | m_drive, m_drive_valid, m_reached, m_target
//  cfg_     | cfg_wr_en (no wait)    | cfg_index, cfg_wdata
//
//  One word per cycle unless stalled; a word passes s1, s2, s3, s4, then the output stage.
//  Ring slot is read into s1 and written back from s1; products and sum have own stages.
//  Reset clears target, ring marks and window sum, sets reached to one; gains reload.
//  All stages advance together; a held result in the output stage stalls s_ready.
module pid_position_windowed_integral #(
    parameter int WINDOW_DEPTH = 10,
    parameter int ANGLE_BITS   = 24
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_wr_en,
    input  logic [pwi_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [pwi_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [1:0]                            s_cmd,
    input  logic signed [pwi_pkg::POS_W-1:0]      s_position,
    input  logic signed [pwi_pkg::SPEED_W-1:0]    s_angular_speed,
    input  logic [1:0]                            s_button,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pwi_pkg::DRIVE_W-1:0]    m_drive,
    output logic                                  m_drive_valid,
    output logic                                  m_reached,
    output logic signed [pwi_pkg::TARGET_W-1:0]   m_target
);
    import pwi_pkg::*;

    localparam int EXT_W     = (ANGLE_BITS > POS_W) ? ANGLE_BITS : POS_W;
    localparam int ERR_W     = EXT_W + 1;
    localparam int SUM_W     = ERR_W + $clog2(WINDOW_DEPTH);
    localparam int SPD_MAG_W = SPEED_W + 1;

    logic signed [GAIN_W-1:0]     gain_p_reg;
    logic signed [GAIN_W-1:0]     gain_i_reg;
    logic signed [GAIN_W-1:0]     gain_d_reg;
    logic [STEP_W-1:0]            small_step_reg;
    logic [STEP_W-1:0]            large_step_reg;
    logic [TOL_W-1:0]             pos_tol_reg;
    logic [TOL_W-1:0]             speed_tol_reg;

    logic signed [ANGLE_BITS-1:0] target_reg;
    logic signed [ANGLE_BITS-1:0] target_next;
    logic                         reached_reg;
    logic                         reached_next;

    logic                         en;
    logic                         accept;
    cmd_t                         cmd;
    logic [STEP_W-1:0]            step;
    logic signed [ERR_W-1:0]      error;
    logic [ERR_W-1:0]             err_mag;
    logic signed [SPD_MAG_W-1:0]  spd_ext;
    logic [SPD_MAG_W-1:0]         spd_mag;
    logic                         stop;

    stage_t                       in_ctrl;
    stage_t                       ring_ctrl;
    stage_t                       out_ctrl;
    logic signed [ERR_W-1:0]      ring_error;
    logic signed [SPEED_W-1:0]    ring_speed;
    logic signed [SUM_W-1:0]      ring_sum;
    logic signed [DRIVE_W-1:0]    drive;

    assign en      = !out_ctrl.valid || m_ready;
    assign s_ready = en;
    assign accept  = s_valid && en;
    assign cmd     = cmd_t'(s_cmd);
    assign step    = s_button[BTN_SIZE_BIT] ? large_step_reg : small_step_reg;

    assign error   = ERR_W'(target_reg) - ERR_W'(s_position);
    assign err_mag = error[ERR_W-1] ? ERR_W'(-error) : ERR_W'(error);
    assign spd_ext = SPD_MAG_W'(s_angular_speed);
    assign spd_mag = spd_ext[SPD_MAG_W-1] ? SPD_MAG_W'(-spd_ext) : SPD_MAG_W'(spd_ext);
    assign stop    = (err_mag <= ERR_W'(pos_tol_reg)) && (spd_mag < SPD_MAG_W'(speed_tol_reg));

    always_comb begin
        target_next  = target_reg;
        reached_next = reached_reg;
        if (accept) begin
            case (cmd)
                CMD_TICK: begin
                    reached_next = stop;
                end
                CMD_BUTTON: begin
                    if (s_button[BTN_DIR_BIT]) begin
                        target_next = target_reg + ANGLE_BITS'(step);
                    end else begin
                        target_next = target_reg - ANGLE_BITS'(step);
                    end
                    reached_next = 1'b0;
                end
                CMD_LOAD: begin
                    target_next = ANGLE_BITS'(s_position);
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        in_ctrl.valid   = accept;
        in_ctrl.tick    = (cmd == CMD_TICK);
        in_ctrl.stop    = stop;
        in_ctrl.reached = reached_next;
        in_ctrl.target  = TARGET_W'(target_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg  <= '0;
            reached_reg <= 1'b1;
        end else begin
            target_reg  <= target_next;
            reached_reg <= reached_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
            small_step_reg <= SMALL_STEP_RST;
            large_step_reg <= LARGE_STEP_RST;
            pos_tol_reg    <= POS_TOL_RST;
            speed_tol_reg  <= SPEED_TOL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_GAIN_P:     gain_p_reg     <= signed'(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_I:     gain_i_reg     <= signed'(cfg_wdata[GAIN_W-1:0]);
                REG_GAIN_D:     gain_d_reg     <= signed'(cfg_wdata[GAIN_W-1:0]);
                REG_SMALL_STEP: small_step_reg <= cfg_wdata[STEP_W-1:0];
                REG_LARGE_STEP: large_step_reg <= cfg_wdata[STEP_W-1:0];
                REG_POS_TOL:    pos_tol_reg    <= cfg_wdata[TOL_W-1:0];
                REG_SPEED_TOL:  speed_tol_reg  <= cfg_wdata[TOL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pwi_ring #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .ERR_W        (ERR_W),
        .SUM_W        (SUM_W)
    ) u_ring (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_ctrl   (in_ctrl),
        .in_error  (error),
        .in_speed  (s_angular_speed),
        .out_ctrl  (ring_ctrl),
        .out_error (ring_error),
        .out_speed (ring_speed),
        .out_sum   (ring_sum)
    );

    pwi_drive #(
        .ERR_W (ERR_W),
        .SUM_W (SUM_W)
    ) u_drive (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_ctrl   (ring_ctrl),
        .in_error  (ring_error),
        .in_speed  (ring_speed),
        .in_sum    (ring_sum),
        .gain_p    (gain_p_reg),
        .gain_i    (gain_i_reg),
        .gain_d    (gain_d_reg),
        .out_ctrl  (out_ctrl),
        .out_drive (drive)
    );

    assign m_valid       = out_ctrl.valid;
    assign m_drive       = drive;
    assign m_drive_valid = out_ctrl.tick;
    assign m_reached     = out_ctrl.reached;
    assign m_target      = signed'(out_ctrl.target);

endmodule
